// ===== rtl/core/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the pressure sample averager.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int ADC_BITS     = 12;
   localparam int MV_W         = ADC_BITS;
   localparam int TIME_W       = 32;
   localparam int FS_W         = 16;
   localparam int IVL_W        = 16;
   localparam int BLEN_W       = 7;
   localparam int WSIZE_W      = 6;
   localparam int KPA_W        = 18;
   localparam int SUM_W        = 18;
   localparam int TOTAL_W      = 24;
   localparam int PROD_W       = MV_W + 1 + FS_W + 1;
   localparam int WINDOW_DEPTH = 32;
   localparam int BURST_MAX    = 64;
   localparam int HEAD_W       = $clog2(WINDOW_DEPTH);

   localparam int DIV_NUM_W    = 29;
   localparam int DIV_DEN_W    = 12;
   localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_LEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 3'd5;

   localparam logic [MV_W-1:0]    RST_SENSOR_MIN  = 12'd500;
   localparam logic [MV_W-1:0]    RST_SENSOR_MAX  = 12'd3000;
   localparam logic [FS_W-1:0]    RST_FULL_SCALE  = 16'd1200;
   localparam logic [IVL_W-1:0]   RST_INTERVAL    = 16'd1000;
   localparam logic [BLEN_W-1:0]  RST_BURST_LEN   = 7'd16;
   localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE = 6'd8;

   // saturation limits of the signed kPa value, as magnitudes
   localparam logic [DIV_NUM_W-1:0] KPA_POS_LIMIT = DIV_NUM_W'((1 << (KPA_W - 1)) - 1);
   localparam logic [DIV_NUM_W-1:0] KPA_NEG_LIMIT = DIV_NUM_W'(1 << (KPA_W - 1));

   typedef enum logic [1:0] {
      DIV_MEAN = 2'd0,
      DIV_KPA  = 2'd1,
      DIV_AVG  = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        cfg_write;
      logic        load_in;
      logic        accum;
      logic        div_start;
      div_sel_type div_sel;
      logic        mean_load;
      logic        kpa_mul;
      logic        kpa_load;
      logic        push;
      logic        avg_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic complete;
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/core/psa_div.sv =====
// ----------------------------------------------------------------------------
// psa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psa_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [psa_pkg::DIV_NUM_W-1:0]  numer,
   input  logic [psa_pkg::DIV_DEN_W-1:0]  denom,
   output logic [psa_pkg::DIV_NUM_W-1:0]  quotient,
   output logic                           done
);
   import psa_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]  den_ff, den_in;
   logic [DIV_DEN_W:0]    trial;
   logic [DIV_DEN_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/core/psa_datapath.sv =====
// ----------------------------------------------------------------------------
// psa_datapath
// Configuration registers, burst accumulator, kPa scaling, moving window
// and result register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module psa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  psa_pkg::cmd_type                    cmd,
   output psa_pkg::sts_type                    sts,
   input  logic [psa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [psa_pkg::MV_W-1:0]            req_reading_mv,
   input  logic [psa_pkg::TIME_W-1:0]          req_now_ms,
   output logic [psa_pkg::MV_W-1:0]            rsp_last_mean_mv,
   output logic signed [psa_pkg::KPA_W-1:0]    rsp_average_kpa,
   output logic                                rsp_have_measure,
   output logic                                rsp_burst_done,
   output logic                                rsp_in_burst
);
   import psa_pkg::*;

   // configuration
   logic [MV_W-1:0]     min_ff, min_in;
   logic [MV_W-1:0]     max_ff, max_in;
   logic [FS_W-1:0]     fs_ff, fs_in;
   logic [IVL_W-1:0]    ivl_ff, ivl_in;
   logic [BLEN_W-1:0]   blen_ff, blen_in;
   logic [WSIZE_W-1:0]  wsize_ff, wsize_in;

   // captured item
   logic [MV_W-1:0]     rd_ff, rd_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // burst state
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [BLEN_W-1:0]   taken_ff, taken_in;
   logic                coll_ff, coll_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic                have_ff, have_in;
   logic [MV_W-1:0]     mean_ff, mean_in;
   logic                done_ff, done_in;

   // scaling and window
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [MV_W-1:0]           span_ff, span_in;
   logic signed [KPA_W-1:0]   kpa_ff, kpa_in;
   logic signed [KPA_W-1:0]   old_ff;
   logic [HEAD_W-1:0]         head_ff, head_in;
   logic [WSIZE_W-1:0]        fill_ff, fill_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic signed [KPA_W-1:0]   avg_ff, avg_in;
   logic signed [KPA_W-1:0]   store_mem [WINDOW_DEPTH];

   // result register
   logic [MV_W-1:0]           out_mean_ff, out_mean_in;
   logic signed [KPA_W-1:0]   out_avg_ff, out_avg_in;
   logic                      out_have_ff, out_have_in;
   logic                      out_done_ff, out_done_in;
   logic                      out_coll_ff, out_coll_in;

   // combinational helpers
   logic [TIME_W-1:0]         elapsed;
   logic                      start_burst;
   logic                      active;
   logic [SUM_W-1:0]          sum_new;
   logic [BLEN_W-1:0]         taken_new;
   logic [BLEN_W-1:0]         burst_eff;
   logic [WSIZE_W-1:0]        window_eff;
   logic signed [MV_W:0]      diff_mv;
   logic [PROD_W-1:0]         prod_abs;
   logic [TOTAL_W-1:0]        total_abs;
   logic [WSIZE_W-1:0]        head_step;
   logic signed [TOTAL_W-1:0] kpa_ext;
   logic signed [TOTAL_W-1:0] old_ext;
   logic [DIV_NUM_W-1:0]      div_numer;
   logic [DIV_DEN_W-1:0]      div_denom;
   logic [DIV_NUM_W-1:0]      quotient;
   logic                      div_done;

   assign elapsed     = now_ff - start_ff;
   assign start_burst = !coll_ff && (!have_ff || (elapsed >= TIME_W'(ivl_ff)));
   assign active      = coll_ff || start_burst;
   assign sum_new     = (start_burst ? '0 : sum_ff) + SUM_W'(rd_ff);
   assign taken_new   = (start_burst ? '0 : taken_ff) + BLEN_W'(1);

   always_comb begin
      if (blen_ff == '0)
         burst_eff = BLEN_W'(1);
      else if (blen_ff > BLEN_W'(BURST_MAX))
         burst_eff = BLEN_W'(BURST_MAX);
      else
         burst_eff = blen_ff;
      if (wsize_ff == '0)
         window_eff = WSIZE_W'(1);
      else if (wsize_ff > WSIZE_W'(WINDOW_DEPTH))
         window_eff = WSIZE_W'(WINDOW_DEPTH);
      else
         window_eff = wsize_ff;
   end

   assign diff_mv   = $signed({1'b0, mean_ff}) - $signed({1'b0, min_ff});
   assign prod_abs  = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign total_abs = total_ff[TOTAL_W-1] ? TOTAL_W'(-total_ff) : TOTAL_W'(total_ff);
   assign head_step = WSIZE_W'(head_ff) + WSIZE_W'(1);
   assign kpa_ext   = $signed({{(TOTAL_W-KPA_W){kpa_ff[KPA_W-1]}}, kpa_ff});
   assign old_ext   = $signed({{(TOTAL_W-KPA_W){old_ff[KPA_W-1]}}, old_ff});

   // operand select for the shared divider; every division rounds half up
   // on a magnitude
   always_comb begin
      unique case (cmd.div_sel)
         DIV_MEAN: begin
            div_numer = DIV_NUM_W'(sum_ff) + DIV_NUM_W'(taken_ff >> 1);
            div_denom = DIV_DEN_W'(taken_ff);
         end
         DIV_KPA: begin
            div_numer = prod_abs[DIV_NUM_W-1:0] + DIV_NUM_W'(span_ff >> 1);
            div_denom = DIV_DEN_W'(span_ff);
         end
         DIV_AVG: begin
            div_numer = DIV_NUM_W'(total_abs) + DIV_NUM_W'(fill_ff >> 1);
            div_denom = DIV_DEN_W'(fill_ff);
         end
         default: begin
            div_numer = '0;
            div_denom = DIV_DEN_W'(1);
         end
      endcase
   end

   psa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .quotient (quotient),
      .done     (div_done)
   );

   assign sts.complete = active && (taken_new >= burst_eff);
   assign sts.div_done = div_done;

   always_comb begin
      min_in      = min_ff;
      max_in      = max_ff;
      fs_in       = fs_ff;
      ivl_in      = ivl_ff;
      blen_in     = blen_ff;
      wsize_in    = wsize_ff;
      rd_in       = rd_ff;
      now_in      = now_ff;
      sum_in      = sum_ff;
      taken_in    = taken_ff;
      coll_in     = coll_ff;
      start_in    = start_ff;
      have_in     = have_ff;
      mean_in     = mean_ff;
      done_in     = done_ff;
      prod_in     = prod_ff;
      span_in     = span_ff;
      kpa_in      = kpa_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      total_in    = total_ff;
      avg_in      = avg_ff;
      out_mean_in = out_mean_ff;
      out_avg_in  = out_avg_ff;
      out_have_in = out_have_ff;
      out_done_in = out_done_ff;
      out_coll_in = out_coll_ff;

      if (cmd.cfg_write) begin
         unique case (csr_index)
            CSR_SENSOR_MIN:  min_in  = csr_wdata[MV_W-1:0];
            CSR_SENSOR_MAX:  max_in  = csr_wdata[MV_W-1:0];
            CSR_FULL_SCALE:  fs_in   = csr_wdata[FS_W-1:0];
            CSR_INTERVAL:    ivl_in  = csr_wdata[IVL_W-1:0];
            CSR_BURST_LEN:   blen_in = csr_wdata[BLEN_W-1:0];
            CSR_WINDOW_SIZE: begin
               // new window size empties the window
               wsize_in = csr_wdata[WSIZE_W-1:0];
               head_in  = '0;
               fill_in  = '0;
               total_in = '0;
               avg_in   = '0;
            end
            default: ;
         endcase
      end

      if (cmd.load_in) begin
         rd_in  = req_reading_mv;
         now_in = req_now_ms;
      end

      if (cmd.accum) begin
         done_in = 1'b0;
         if (active) begin
            sum_in   = sum_new;
            taken_in = taken_new;
            coll_in  = 1'b1;
         end
         if (start_burst)
            start_in = now_ff;
      end

      if (cmd.mean_load) begin
         mean_in  = quotient[MV_W-1:0];
         have_in  = 1'b1;
         coll_in  = 1'b0;
         sum_in   = '0;
         taken_in = '0;
         done_in  = 1'b1;
      end

      if (cmd.kpa_mul) begin
         prod_in = diff_mv * $signed({1'b0, fs_ff});
         span_in = (max_ff > min_ff) ? (max_ff - min_ff) : MV_W'(1);
      end

      if (cmd.kpa_load) begin
         if (prod_ff[PROD_W-1]) begin
            if (quotient > KPA_NEG_LIMIT)
               kpa_in = $signed(KPA_NEG_LIMIT[KPA_W-1:0]);
            else
               kpa_in = -$signed(quotient[KPA_W-1:0]);
         end else begin
            if (quotient > KPA_POS_LIMIT)
               kpa_in = $signed(KPA_POS_LIMIT[KPA_W-1:0]);
            else
               kpa_in = $signed(quotient[KPA_W-1:0]);
         end
      end

      if (cmd.push) begin
         if (fill_ff < window_eff) begin
            total_in = total_ff + kpa_ext;
            fill_in  = fill_ff + WSIZE_W'(1);
         end else begin
            // window full: replace the oldest entry
            total_in = total_ff + kpa_ext - old_ext;
         end
         head_in = (head_step >= window_eff) ? '0 : head_step[HEAD_W-1:0];
      end

      if (cmd.avg_load) begin
         if (total_ff[TOTAL_W-1])
            avg_in = -$signed(quotient[KPA_W-1:0]);
         else
            avg_in = $signed(quotient[KPA_W-1:0]);
      end

      if (cmd.out_load) begin
         out_mean_in = mean_ff;
         out_avg_in  = avg_ff;
         out_have_in = have_ff;
         out_done_in = done_ff;
         out_coll_in = coll_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= RST_SENSOR_MIN;
         max_ff   <= RST_SENSOR_MAX;
         fs_ff    <= RST_FULL_SCALE;
         ivl_ff   <= RST_INTERVAL;
         blen_ff  <= RST_BURST_LEN;
         wsize_ff <= RST_WINDOW_SIZE;
         sum_ff   <= '0;
         taken_ff <= '0;
         coll_ff  <= 1'b0;
         start_ff <= '0;
         have_ff  <= 1'b0;
         mean_ff  <= '0;
         done_ff  <= 1'b0;
         head_ff  <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
         avg_ff   <= '0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         fs_ff    <= fs_in;
         ivl_ff   <= ivl_in;
         blen_ff  <= blen_in;
         wsize_ff <= wsize_in;
         sum_ff   <= sum_in;
         taken_ff <= taken_in;
         coll_ff  <= coll_in;
         start_ff <= start_in;
         have_ff  <= have_in;
         mean_ff  <= mean_in;
         done_ff  <= done_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         avg_ff   <= avg_in;
      end
      rd_ff       <= rd_in;
      now_ff      <= now_in;
      prod_ff     <= prod_in;
      span_ff     <= span_in;
      kpa_ff      <= kpa_in;
      out_mean_ff <= out_mean_in;
      out_avg_ff  <= out_avg_in;
      out_have_ff <= out_have_in;
      out_done_ff <= out_done_in;
      out_coll_ff <= out_coll_in;
   end

   // window ring: fetch the slot about to be overwritten, write on push
   always_ff @(posedge clock) begin
      if (cmd.kpa_mul)
         old_ff <= store_mem[head_ff];
      if (cmd.push)
         store_mem[head_ff] <= kpa_ff;
   end

   assign rsp_last_mean_mv = out_mean_ff;
   assign rsp_average_kpa  = out_avg_ff;
   assign rsp_have_measure = out_have_ff;
   assign rsp_burst_done   = out_done_ff;
   assign rsp_in_burst     = out_coll_ff;

endmodule

// ===== rtl/core/psa_ctrl.sv =====
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer: takes one reading, steps the datapath through accumulate and, at
// burst end, mean, scaling, window update and average; hands the result over.
// ----------------------------------------------------------------------------
module psa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  psa_pkg::sts_type  sts,
   output psa_pkg::cmd_type  cmd
);
   import psa_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_ACCUM    = 11'b000_0000_0010,
      ST_MEAN_GO  = 11'b000_0000_0100,
      ST_MEAN_WT  = 11'b000_0000_1000,
      ST_KPA_MUL  = 11'b000_0001_0000,
      ST_KPA_GO   = 11'b000_0010_0000,
      ST_KPA_WT   = 11'b000_0100_0000,
      ST_PUSH     = 11'b000_1000_0000,
      ST_AVG_GO   = 11'b001_0000_0000,
      ST_AVG_WT   = 11'b010_0000_0000,
      ST_RESULT   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_MEAN;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.cfg_write = csr_valid;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = sts.complete ? ST_MEAN_GO : ST_RESULT;
         end
         ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
            state_in      = ST_MEAN_WT;
         end
         ST_MEAN_WT: begin
            if (sts.div_done) begin
               cmd.mean_load = 1'b1;
               state_in      = ST_KPA_MUL;
            end
         end
         ST_KPA_MUL: begin
            cmd.kpa_mul = 1'b1;
            state_in    = ST_KPA_GO;
         end
         ST_KPA_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_KPA;
            state_in      = ST_KPA_WT;
         end
         ST_KPA_WT: begin
            if (sts.div_done) begin
               cmd.kpa_load = 1'b1;
               state_in     = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_AVG_GO;
         end
         ST_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_AVG;
            state_in      = ST_AVG_WT;
         end
         ST_AVG_WT: begin
            if (sts.div_done) begin
               cmd.avg_load = 1'b1;
               state_in     = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/pressure_sample_averager.sv =====
// ----------------------------------------------------------------------------
// pressure_sample_averager
// Burst averaging of ADC readings with kPa scaling and a moving window.
// ----------------------------------------------------------------------------
// One reading is taken at a time. A reading that does not end a burst goes
// straight from accumulation to the result; a reading that ends a burst waits
// on the shared 29-bit divider (one quotient bit per cycle), which runs three
// times in a row: burst mean, kPa scaling and window average. A new reading is
// taken while the previous result still waits in the output register.
// Configuration writes are taken whenever no reading is in work; writing the
// window size empties the window.
module pressure_sample_averager (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [psa_pkg::MV_W-1:0]            req_reading_mv,
   input  logic [psa_pkg::TIME_W-1:0]          req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [psa_pkg::MV_W-1:0]            rsp_last_mean_mv,
   output logic signed [psa_pkg::KPA_W-1:0]    rsp_average_kpa,
   output logic                                rsp_have_measure,
   output logic                                rsp_burst_done,
   output logic                                rsp_in_burst,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import psa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   psa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   psa_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_reading_mv   (req_reading_mv),
      .req_now_ms       (req_now_ms),
      .rsp_last_mean_mv (rsp_last_mean_mv),
      .rsp_average_kpa  (rsp_average_kpa),
      .rsp_have_measure (rsp_have_measure),
      .rsp_burst_done   (rsp_burst_done),
      .rsp_in_burst     (rsp_in_burst)
   );

endmodule

// ===== rtl/core/psa_checker.sv =====
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks of the pressure sample averager, bound to the top level.
// ----------------------------------------------------------------------------
module psa_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [psa_pkg::MV_W-1:0]            rsp_last_mean_mv,
   input  logic signed [psa_pkg::KPA_W-1:0]    rsp_average_kpa,
   input  logic                                rsp_have_measure,
   input  logic                                rsp_burst_done,
   input  logic                                rsp_in_burst
);
   import psa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // one reading at a time: a transfer makes the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again without processing");

   a_done_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_burst_done |-> rsp_have_measure && !rsp_in_burst)
      else $error("burst end flags inconsistent");

   // before the first burst ends, mean and window average are zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_have_measure |->
         rsp_last_mean_mv == '0 && rsp_average_kpa == '0 && !rsp_burst_done)
      else $error("nonzero result before any measurement");

endmodule

bind pressure_sample_averager psa_checker u_psa_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pressure sample averager.
// ----------------------------------------------------------------------------
// Readings go in through a bursty driver and results come back through a
// receiver that stalls on its own pattern. Each accepted reading is run
// through a local copy of the burst, scaling and window logic. Every result
// is compared field by field with the oldest prediction. A directed opening
// covers the field extremes, saturation, a non-positive span, the interval
// and timestamp wrap, and a burst length lowered mid-burst. Random setting
// phases follow, with mostly well-formed bursts and some stray readings.
// ----------------------------------------------------------------------------
module tb;
   import psa_pkg::*;

   localparam int     QUIET_LIMIT = 4000;
   localparam int     HOLD_CYCLES = 400;
   localparam int     TAIL_CYCLES = 200;
   localparam int     ITEM_TARGET = 1750;
   localparam longint KPA_HI      = 131071;
   localparam longint KPA_LO      = -131072;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [MV_W-1:0]   mv;
      logic [TIME_W-1:0] ms;
   } reading_type;

   typedef struct packed {
      logic [MV_W-1:0]         last_mean_mv;
      logic signed [KPA_W-1:0] average_kpa;
      logic                    have_measure;
      logic                    burst_done;
      logic                    in_burst;
   } gauge_type;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_LIGHT,
      DRAIN_HEAVY,
      DRAIN_PERIODIC
   } drain_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MV_W-1:0]         req_reading_mv = '0;
   logic [TIME_W-1:0]       req_now_ms = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [MV_W-1:0]         rsp_last_mean_mv;
   logic signed [KPA_W-1:0] rsp_average_kpa;
   logic                    rsp_have_measure;
   logic                    rsp_burst_done;
   logic                    rsp_in_burst;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   pressure_sample_averager dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // local copy of the settings and the measurement state
   logic [MV_W-1:0]         cfg_min_mv;
   logic [MV_W-1:0]         cfg_max_mv;
   logic [FS_W-1:0]         cfg_full_kpa;
   logic [IVL_W-1:0]        cfg_interval;
   logic [BLEN_W-1:0]       cfg_burst_len;
   logic [WSIZE_W-1:0]      cfg_window;
   logic [SUM_W-1:0]        acc_sum;
   logic [BLEN_W-1:0]       acc_count;
   logic                    acc_active;
   logic [TIME_W-1:0]       acc_start_ms;
   logic                    have_mean;
   logic [MV_W-1:0]         mean_mv;
   logic signed [KPA_W-1:0] ring_kpa [WINDOW_DEPTH];
   int unsigned             ring_head;
   int unsigned             ring_fill;
   longint                  ring_total;

   reading_type    reading_queue[$];
   gauge_type      expected_gauges[$];
   bit             req_took;
   bit             sender_calm;
   bit             hold_ask;
   int unsigned    run_left;
   int unsigned    idle_left;
   int unsigned    hold_left;
   int unsigned    mode_left;
   int unsigned    tick;
   drain_mode_type drain_mode = DRAIN_FREE;
   int unsigned    quiet;
   int unsigned    mismatches;
   int unsigned    readings_in;
   int unsigned    results_seen;
   int unsigned    bursts_seen;
   int unsigned    cfg_writes;
   int unsigned    holds_done;
   int unsigned    planned_items;
   int unsigned    gen_now;
   int unsigned    gen_start;
   int unsigned    gen_need;
   int unsigned    gen_gap;

   function automatic longint div_round(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic int unsigned clamp_len(int unsigned v, int unsigned top);
      return (v < 1) ? 1 : ((v > top) ? top : v);
   endfunction

   function automatic logic signed [KPA_W-1:0] scale_to_kpa(logic [MV_W-1:0] mv);
      longint span;
      longint k;
      span = longint'(cfg_max_mv) - longint'(cfg_min_mv);
      if (span <= 0) span = 1;
      k = div_round((longint'(mv) - longint'(cfg_min_mv)) * longint'(cfg_full_kpa), span);
      if (k > KPA_HI) k = KPA_HI;
      if (k < KPA_LO) k = KPA_LO;
      return KPA_W'(k);
   endfunction

   function automatic gauge_type predict_gauge(reading_type rd);
      gauge_type               g;
      int unsigned             need;
      int unsigned             win_size;
      int unsigned             slot;
      logic signed [KPA_W-1:0] kpa;
      g.burst_done = 1'b0;
      if (!acc_active && (!have_mean || (rd.ms - acc_start_ms) >= TIME_W'(cfg_interval))) begin
         acc_active   = 1'b1;
         acc_sum      = '0;
         acc_count    = '0;
         acc_start_ms = rd.ms;
      end
      if (acc_active) begin
         acc_sum   = acc_sum + SUM_W'(rd.mv);
         acc_count = acc_count + 1'b1;
         need      = clamp_len(cfg_burst_len, BURST_MAX);
         if (acc_count >= need) begin
            mean_mv  = MV_W'((int'(acc_sum) + int'(acc_count) / 2) / int'(acc_count));
            kpa      = scale_to_kpa(mean_mv);
            win_size = clamp_len(cfg_window, WINDOW_DEPTH);
            slot     = ring_head % WINDOW_DEPTH;
            if (ring_fill < win_size) begin
               ring_total += longint'(kpa);
               ring_fill++;
            end else begin
               ring_total += longint'(kpa) - longint'(ring_kpa[slot]);
            end
            ring_kpa[slot] = kpa;
            ring_head  = (ring_head + 1 >= win_size) ? 0 : ring_head + 1;
            have_mean  = 1'b1;
            acc_active = 1'b0;
            acc_sum    = '0;
            acc_count  = '0;
            g.burst_done = 1'b1;
         end
      end
      g.last_mean_mv = mean_mv;
      g.average_kpa  = (ring_fill > 0) ?
                       KPA_W'(div_round(ring_total, longint'(ring_fill))) : '0;
      g.have_measure = have_mean;
      g.in_burst     = acc_active;
      return g;
   endfunction

   task automatic reset_model();
      cfg_min_mv    = RST_SENSOR_MIN;
      cfg_max_mv    = RST_SENSOR_MAX;
      cfg_full_kpa  = RST_FULL_SCALE;
      cfg_interval  = RST_INTERVAL;
      cfg_burst_len = RST_BURST_LEN;
      cfg_window    = RST_WINDOW_SIZE;
      acc_sum       = '0;
      acc_count     = '0;
      acc_active    = 1'b0;
      acc_start_ms  = '0;
      have_mean     = 1'b0;
      mean_mv       = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) ring_kpa[i] = '0;
      ring_head  = 0;
      ring_fill  = 0;
      ring_total = 0;
      gen_need   = RST_BURST_LEN;
      gen_gap    = RST_INTERVAL;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // sample everything on the rising edge: settings, readings, results, watchdog
   always @(posedge clock) begin : observe
      gauge_type want;
      reading_type rd;
      req_took = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_burst_done) bursts_seen++;
            if (expected_gauges.size() == 0) begin
               $display("%0t: result with nothing pending, last_mean_mv %0d average_kpa %0d",
                        $time, rsp_last_mean_mv, rsp_average_kpa);
               mismatches++;
            end else begin
               want = expected_gauges.pop_front();
               check_field("last_mean_mv", want.last_mean_mv, rsp_last_mean_mv);
               check_field("average_kpa", $signed(want.average_kpa), $signed(rsp_average_kpa));
               check_field("have_measure", want.have_measure, rsp_have_measure);
               check_field("burst_done", want.burst_done, rsp_burst_done);
               check_field("in_burst", want.in_burst, rsp_in_burst);
            end
         end
         if (req_took) begin
            rd.mv = req_reading_mv;
            rd.ms = req_now_ms;
            expected_gauges.push_back(predict_gauge(rd));
            readings_in++;
         end
         if (csr_valid && csr_ready) begin
            cfg_writes++;
            case (csr_index)
               CSR_SENSOR_MIN:  cfg_min_mv    = csr_wdata[MV_W-1:0];
               CSR_SENSOR_MAX:  cfg_max_mv    = csr_wdata[MV_W-1:0];
               CSR_FULL_SCALE:  cfg_full_kpa  = csr_wdata[FS_W-1:0];
               CSR_INTERVAL:    cfg_interval  = csr_wdata[IVL_W-1:0];
               CSR_BURST_LEN:   cfg_burst_len = csr_wdata[BLEN_W-1:0];
               CSR_WINDOW_SIZE: begin
                  cfg_window = csr_wdata[WSIZE_W-1:0];
                  ring_head  = 0;
                  ring_fill  = 0;
                  ring_total = 0;
               end
               default: ;
            endcase
         end
         if (req_took || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (sender_calm || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 6);
      if (r < 97) return $urandom_range(7, 40);
      return $urandom_range(41, 130);
   endfunction

   // sender: runs of transfers separated by idle gaps
   always @(negedge clock) begin : feed
      reading_type rd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (idle_left > 0) begin
            idle_left--;
            req_valid <= 1'b0;
         end else if (reading_queue.size() != 0) begin
            rd = reading_queue.pop_front();
            req_valid      <= 1'b1;
            req_reading_mv <= rd.mv;
            req_now_ms     <= rd.ms;
            if (run_left > 0) begin
               run_left--;
            end else begin
               run_left  = $urandom_range(1, 24);
               idle_left = pick_idle();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern picked at random and changed when its run ends; long hold on request
   always @(negedge clock) begin : drain
      if (hold_ask && hold_left == 0) begin
         hold_left = HOLD_CYCLES;
         hold_ask  = 1'b0;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            drain_mode = drain_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         tick++;
         case (drain_mode)
            DRAIN_FREE:  rsp_stall <= 1'b0;
            DRAIN_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            DRAIN_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((tick % 7) < 3);
         endcase
      end
   end

   task automatic queue_reading(input int unsigned mv, input int unsigned ms);
      reading_type rd;
      rd.mv = MV_W'(mv);
      rd.ms = ms;
      reading_queue.push_back(rd);
   endtask

   task automatic drain_all();
      do @(negedge clock);
      while (reading_queue.size() != 0 || req_valid || expected_gauges.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_BURST_LEN) gen_need = clamp_len(val[BLEN_W-1:0], BURST_MAX);
      if (idx == CSR_INTERVAL) gen_gap = val[IVL_W-1:0];
   endtask

   task automatic configure(input int unsigned lo, input int unsigned hi, input int unsigned fs,
                            input int unsigned gap, input int unsigned blen,
                            input int unsigned wsize);
      drain_all();
      write_reg(CSR_SENSOR_MIN, CSR_DATA_W'(lo));
      write_reg(CSR_SENSOR_MAX, CSR_DATA_W'(hi));
      write_reg(CSR_FULL_SCALE, CSR_DATA_W'(fs));
      write_reg(CSR_INTERVAL, CSR_DATA_W'(gap));
      write_reg(CSR_BURST_LEN, CSR_DATA_W'(blen));
      write_reg(CSR_WINDOW_SIZE, CSR_DATA_W'(wsize));
   endtask

   task automatic random_config(input int phase);
      int unsigned lo, hi, fs, gap, blen, wsize, r;
      r  = $urandom_range(0, 99);
      lo = (r < 25) ? 0 : ((r < 35) ? 4095 : $urandom_range(0, 3000));
      r  = $urandom_range(0, 99);
      if (r < 10) hi = $urandom_range(0, lo);
      else if (r < 20 || lo == 4095) hi = 4095;
      else hi = $urandom_range(lo + 1, 4095);
      r  = $urandom_range(0, 99);
      fs = (r < 15) ? 65535 : (r < 25) ? 1 : (r < 30) ? 0 :
           (r < 50) ? $urandom_range(1, 65535) : $urandom_range(1, 5000);
      r   = $urandom_range(0, 99);
      gap = (r < 20) ? 0 : (r < 30) ? 65535 :
            (r < 80) ? $urandom_range(1, 50) : $urandom_range(0, 65535);
      r = $urandom_range(0, 99);
      if (phase == 0) blen = 127;
      else blen = (r < 5) ? 0 : (r < 10) ? 64 : (r < 15) ? $urandom_range(65, 127) :
                  (r < 75) ? $urandom_range(1, 8) : $urandom_range(9, 63);
      r = $urandom_range(0, 99);
      if (phase == 0) wsize = 32;
      else wsize = (r < 5) ? 0 : (r < 15) ? 32 : (r < 20) ? $urandom_range(33, 63) :
                   $urandom_range(1, 31);
      // junk in the unused upper data bits
      if ($urandom_range(0, 3) == 0) begin
         lo    |= $urandom_range(0, 15) << MV_W;
         hi    |= $urandom_range(0, 15) << MV_W;
         blen  |= $urandom_range(0, 511) << BLEN_W;
         wsize |= $urandom_range(0, 1023) << WSIZE_W;
      end
      configure(lo, hi, fs, gap, blen, wsize);
   endtask

   // one well-formed burst, then a few readings that fall inside the interval
   task automatic add_burst();
      int unsigned base, style, mv;
      style = $urandom_range(0, 3);
      base  = $urandom_range(0, 4095);
      if (gen_now - gen_start < gen_gap) gen_now = gen_start + gen_gap;
      gen_now  += $urandom_range(0, 2);
      gen_start = gen_now;
      for (int i = 0; i < gen_need; i++) begin
         case (style)
            0: mv = $urandom_range(0, 4095);
            1: begin
               mv = base + $urandom_range(0, 32);
               mv = (mv < 16) ? 0 : ((mv - 16 > 4095) ? 4095 : mv - 16);
            end
            2: mv = base[0] ? 4095 : 0;
            default: mv = $urandom_range(0, 1) ? 4095 : 0;
         endcase
         queue_reading(mv, gen_now);
         gen_now += $urandom_range(0, 2);
      end
      planned_items += gen_need;
      repeat ($urandom_range(0, 3)) begin
         if (gen_now - gen_start < gen_gap) begin
            queue_reading($urandom_range(0, 4095), gen_now);
            gen_now += $urandom_range(0, 1);
            planned_items++;
         end
      end
   endtask

   initial begin : stimulus
      int unsigned phase_end;
      int          phase;
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // two readings under the reset settings leave a burst open
      queue_reading(4095, 32'h0000_0010);
      queue_reading(4095, 32'h0000_0011);
      drain_all();
      write_reg(CSR_SPARE_6, 16'hFFFF);
      write_reg(CSR_SPARE_7, 16'hFFFF);
      // burst length drops to one: the open burst ends on the next reading
      configure(0, 4095, 65535, 0, 1, 2);
      queue_reading(0, 32'h0000_0012);
      queue_reading(4095, 32'hFFFF_FFFF);
      queue_reading(0, 32'hFFFF_FFFF);
      queue_reading(2048, 32'h0000_0000);
      // saturate both ways, then a span that is not positive
      configure(0, 1, 65535, 0, 1, 3);
      queue_reading(4095, 1);
      queue_reading(4095, 2);
      queue_reading(0, 3);
      configure(4095, 4095, 65535, 0, 1, 0);
      queue_reading(0, 4);
      queue_reading(4095, 5);
      configure(3000, 100, 65535, 0, 1, 2);
      queue_reading(0, 6);
      queue_reading(4095, 7);
      // longest interval across the timestamp wrap, oversized window
      configure(500, 3000, 1200, 65535, 2, 63);
      queue_reading(1000, 32'hFFFF_FFF0);
      queue_reading(3000, 32'hFFFF_FFF1);
      queue_reading(4095, 32'h0000_0005);
      queue_reading(0, 32'h0000_FFEF);
      queue_reading(100, 32'h0000_FFF0);
      planned_items = 18;
      gen_now   = 32'h0000_FFF1;
      gen_start = 32'h0000_FFEF;

      phase = 0;
      while (planned_items < ITEM_TARGET) begin
         random_config(phase);
         sender_calm = (phase < 2) || ($urandom_range(0, 3) == 0);
         if (phase < 2) hold_ask = 1'b1;
         if ($urandom_range(0, 7) == 0) gen_now = $urandom;
         phase_end = planned_items + $urandom_range(40, 200);
         while (planned_items < phase_end) begin
            if ($urandom_range(0, 99) < 8) begin
               gen_now = $urandom;
               queue_reading($urandom_range(0, 4095), gen_now);
               planned_items++;
            end else begin
               add_burst();
            end
         end
         phase++;
      end

      drain_all();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_gauges.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_gauges.size());
         mismatches++;
      end
      $display("Run covered %0d readings, %0d completed bursts, %0d register writes, %0d phases",
               readings_in, bursts_seen, cfg_writes, phase + 5);
      $display("Checked %0d results with %0d long output holds; %0d field errors",
               results_seen, holds_done, mismatches);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
